>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// ante |-> cons, sampled on the rising edge, off while in reset
`define RLTK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante |=> cons, sampled on the rising edge, off while in reset
`define RLTK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RLTK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RLTK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/rltk_pkg.sv
package rltk_pkg;

  localparam int STAMP_W    = 32;
  localparam int INTERVAL_W = 32;
  localparam int SUM_OUT_W  = 39;
  localparam int WHOLE_W    = 32;
  localparam int FRAC_W     = 7;
  localparam int RANK_W     = 4;
  localparam int LARGEST_W  = 32;

  localparam int HUNDRED    = 100;
  // ring depth; a power of two so the average is a shift and a mask
  localparam int WINDOW     = 128;
  localparam int PTR_W      = $clog2(WINDOW);

  typedef enum logic {
    ACT_EVENT = 1'b0,
    ACT_CLEAR = 1'b1
  } action_t;

  typedef struct packed {
    action_t              action;
    logic [STAMP_W-1:0]   timestamp;
  } in_item_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] interval;
    logic [SUM_OUT_W-1:0]  window_sum;
    logic [WHOLE_W-1:0]    average_whole;
    logic [FRAC_W-1:0]     average_hundredths;
    logic [RANK_W-1:0]     insert_rank;
    logic                  top_changed;
    logic [LARGEST_W-1:0]  top_largest;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic insert;
    logic clear;
  } cell_ctl_t;

endpackage

>>> hw/rtl/rltk_cell.sv
module rltk_cell #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rltk_pkg::cell_ctl_t   ctl,
  input  logic [TIME_WIDTH-1:0] iv,
  input  logic [TIME_WIDTH-1:0] prev_entry,
  input  logic                  ins_in,
  output logic [TIME_WIDTH-1:0] entry,
  output logic                  ins_out,
  output logic                  hit
);

  logic [TIME_WIDTH-1:0] entry_r, entry_nxt;
  logic                  gt;

  // insertion point is the first cell whose entry is below iv
  assign gt      = iv > entry_r;
  assign ins_out = ins_in | gt;
  assign hit     = ~ins_in & gt;
  assign entry   = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.clear) begin
      entry_nxt = '0;
    end else if (ctl.insert) begin
      if (ins_in) begin
        entry_nxt = prev_entry;
      end else if (gt) begin
        entry_nxt = iv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

>>> hw/rtl/rltk_div.sv
module rltk_div #(
  parameter int DIVD_W = 39
) (
  input  logic [DIVD_W-1:0]                 dividend,
  output logic [DIVD_W-rltk_pkg::PTR_W-1:0] quot,
  output logic [rltk_pkg::FRAC_W-1:0]       frac
);

  localparam int PW = rltk_pkg::PTR_W;
  localparam int MW = PW + rltk_pkg::FRAC_W;

  logic [MW-1:0] scaled;

  // divide by WINDOW: quotient is a shift, remainder a mask
  assign quot   = dividend[DIVD_W-1:PW];
  // hundredths: remainder * 100 / WINDOW, truncated
  assign scaled = MW'(dividend[PW-1:0]) * MW'(rltk_pkg::HUNDRED);
  assign frac   = scaled[MW-1:PW];

endmodule

>>> hw/rtl/roundtrip_latency_top_k_tracker.sv
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    rltk_pkg::in_item_t
// out_     output     out_valid / out_ready  rltk_pkg::out_item_t
//
// Each item steps through accept, update (ring read data, running sum, top-K
// row) and load, which waits until the output register is free; no new item is
// accepted before load. The average is the sum shifted by log2(WINDOW), hundredths
// come from the remainder times 100 shifted the same way.
// Reset is synchronous; a wrap flag makes ring entries read as zero until the
// first lap is written, so there is no clearing pass after reset.
// The result waits in an output register; the next item is accepted meanwhile,
// and the sequencer holds its result in the load state until the register is free.
`include "assert_macros.svh"

module roundtrip_latency_top_k_tracker #(
  parameter int TOPK       = 8,
  parameter int TIME_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rltk_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rltk_pkg::out_item_t out_item
);

  localparam int WINDOW  = rltk_pkg::WINDOW;
  localparam int PTR_W   = rltk_pkg::PTR_W;
  localparam int SUM_W   = TIME_WIDTH + PTR_W;
  localparam int RANK_IW = $clog2(TOPK + 1);
  localparam int IV_OW   = rltk_pkg::INTERVAL_W;
  localparam int SUM_OW  = rltk_pkg::SUM_OUT_W;
  localparam int WH_OW   = rltk_pkg::WHOLE_W;
  localparam int FR_OW   = rltk_pkg::FRAC_W;
  localparam int RK_OW   = rltk_pkg::RANK_W;
  localparam int LG_OW   = rltk_pkg::LARGEST_W;

  rltk_pkg::state_t    st_r, st_nxt;
  rltk_pkg::action_t   act_r;
  logic                started_r;
  logic [TIME_WIDTH-1:0] last_r;
  logic [TIME_WIDTH-1:0] iv_r;
  logic [TIME_WIDTH-1:0] iv_new;
  logic [TIME_WIDTH-1:0] now;
  logic [PTR_W-1:0]    pos_r;
  logic [PTR_W-1:0]    pos_inc;
  logic                wrapped_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [TIME_WIDTH-1:0] rd_data_r;
  logic [TIME_WIDTH-1:0] old_iv;
  logic [TIME_WIDTH-1:0] ring_mem [WINDOW];
  logic [RANK_IW-1:0]  rank_r, rank_now;
  logic                chg_r, chg_now;
  logic [TIME_WIDTH-1:0] avg_whole;
  logic [FR_OW-1:0]    avg_frac;
  logic                out_valid_r;
  rltk_pkg::out_item_t out_r;

  logic accept, upd, ev_upd, clr_upd, load, pos_last;

  logic [TIME_WIDTH-1:0] entry [TOPK];
  logic [TOPK:0]         ins;
  logic [TOPK-1:0]       hit;
  rltk_pkg::cell_ctl_t   ctl [TOPK];

  // ---------------- sequencer ----------------
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rltk_pkg::ST_IDLE:  if (in_valid) st_nxt = rltk_pkg::ST_UPD;
      rltk_pkg::ST_UPD:   st_nxt = rltk_pkg::ST_LOAD;
      rltk_pkg::ST_LOAD:  if (!out_valid_r || out_ready) st_nxt = rltk_pkg::ST_IDLE;
      default:            st_nxt = rltk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (st_r == rltk_pkg::ST_IDLE);
    upd       = (st_r == rltk_pkg::ST_UPD);
    ev_upd    = upd && (act_r == rltk_pkg::ACT_EVENT);
    clr_upd   = upd && (act_r == rltk_pkg::ACT_CLEAR);
    load      = (st_r == rltk_pkg::ST_LOAD) && (!out_valid_r || out_ready);
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rltk_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // ---------------- timing ----------------
  assign now    = in_item.timestamp[TIME_WIDTH-1:0];
  assign iv_new = (in_item.action == rltk_pkg::ACT_EVENT && started_r) ? now - last_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      last_r    <= '0;
    end else if (accept && in_item.action == rltk_pkg::ACT_EVENT) begin
      started_r <= 1'b1;
      last_r    <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_item.action;
      iv_r  <= iv_new;
    end
  end

  // ---------------- interval ring and running sum ----------------
  assign pos_last = (pos_r == PTR_W'(WINDOW - 1));
  assign pos_inc  = pos_last ? '0 : pos_r + 1'b1;
  assign old_iv   = wrapped_r ? rd_data_r : '0;

  always_comb begin
    sum_nxt = sum_r;
    if (ev_upd) begin
      sum_nxt = sum_r - SUM_W'(old_iv) + SUM_W'(iv_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      wrapped_r <= 1'b0;
      sum_r     <= '0;
    end else begin
      sum_r <= sum_nxt;
      if (ev_upd) begin
        pos_r <= pos_inc;
        if (pos_last) begin
          wrapped_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_upd) begin
      ring_mem[pos_r] <= iv_r;
    end
    rd_data_r <= ring_mem[pos_r];
  end

  // ---------------- top-K cell row ----------------
  assign ins[0] = 1'b0;

  for (genvar i = 0; i < TOPK; i++) begin : g_cell
    logic [TIME_WIDTH-1:0] prev;
    if (i == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = entry[i-1];
    end
    assign ctl[i].insert = ev_upd;
    assign ctl[i].clear  = clr_upd && (i == 0);

    rltk_cell #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl[i]),
      .iv         (iv_r),
      .prev_entry (prev),
      .ins_in     (ins[i]),
      .entry      (entry[i]),
      .ins_out    (ins[i+1]),
      .hit        (hit[i])
    );
  end

  always_comb begin
    rank_now = RANK_IW'(TOPK);
    for (int i = TOPK - 1; i >= 0; i--) begin
      if (hit[i]) begin
        rank_now = RANK_IW'(i);
      end
    end
    if (act_r == rltk_pkg::ACT_CLEAR) begin
      rank_now = RANK_IW'(TOPK);
      chg_now  = (entry[0] != '0);
    end else begin
      chg_now  = |hit;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      rank_r <= rank_now;
      chg_r  <= chg_now;
    end
  end

  // ---------------- average: whole part and hundredths ----------------
  rltk_div #(
    .DIVD_W (SUM_W)
  ) u_div (
    .dividend (sum_r),
    .quot     (avg_whole),
    .frac     (avg_frac)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.interval           <= IV_OW'(iv_r);
      out_r.window_sum         <= SUM_OW'(sum_r);
      out_r.average_whole      <= WH_OW'(avg_whole);
      out_r.average_hundredths <= avg_frac;
      out_r.insert_rank        <= RK_OW'(rank_r);
      out_r.top_changed        <= chg_r;
      out_r.top_largest        <= LG_OW'(entry[0]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `RLTK_ASSERT_IMP(a_hit_single, clk, rst_n, upd, $onehot0(hit), "more than one insertion point")
  `RLTK_ASSERT_IMP(a_ins_hit, clk, rst_n, upd, ins[TOPK] == (|hit), "insertion chain mismatch")
  `RLTK_ASSERT_NEXT(a_pos_step, clk, rst_n, ev_upd, pos_r == $past(pos_inc), "ring position stuck")
  `RLTK_ASSERT_NEXT(a_clear_sum, clk, rst_n, clr_upd, $stable(sum_r), "clear changed the running sum")
  `RLTK_ASSERT_NEXT(a_load_out, clk, rst_n, load, out_valid_r && in_ready, "result not loaded")

endmodule
